@@ sv/sqrot_pkg.sv @@
// Shared constants and types for the square matrix clockwise rotator.
package sqrot_pkg;

  localparam int MAX_SIDE = 8;
  localparam int IDX_W    = $clog2(MAX_SIDE);
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
  localparam int DATA_W   = 32;
  localparam int SIZE_W   = 4;

  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_SIDE);
  localparam logic [IDX_W-1:0]  IDX_TOP  = IDX_W'(MAX_SIDE - 1);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DATA_W-1:0] word_t;

  typedef enum logic {
    ST_LOAD,
    ST_READ
  } state_t;

endpackage

@@ sv/square_matrix_rotate_cw.sv @@
// Square matrix rotator: loads an n-by-n matrix and emits it turned 90 degrees clockwise.
//
// Usage: set the side n through the cfg channel (values 1 to 8; 0 acts as 1 and
// anything above 8 acts as 8). A write discards a partly loaded matrix. Then
// send n*n elements on the in channel in row-major order. Each request writes
// one entry of a 64-word buffer, one element per cycle in the load state. After the last element
// the block reads the buffer in rotated order, one entry per cycle unless the
// receiver stalls, and the out channel delivers the rotated matrix in row-major
// order with its row, column and a last flag on the final element.
// After the last element is taken the state register turns to readout, and the
// first result is then registered at the buffer's read port. Loading and readout
// do not overlap: no new elements are taken while a matrix is read out.
// The buffer's registered read data is the output register, so a stalled
// receiver simply halts the readout; once the last read is issued the block
// takes the elements of the next matrix while the final result still waits.
// Reset sets the side to 8 and empties the load and readout counters; the
// buffer contents are not cleared.
module square_matrix_rotate_cw (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [sqrot_pkg::DATA_W-1:0] in_element,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [sqrot_pkg::DATA_W-1:0] out_rotated_element,
  output logic [sqrot_pkg::IDX_W-1:0]    out_row,
  output logic [sqrot_pkg::IDX_W-1:0]    out_col,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sqrot_pkg::SIZE_W-1:0]   cfg_matrix_size
);
  import sqrot_pkg::*;

  state_t state_r, state_nxt;

  idx_t  side_m1_r;
  idx_t  ld_row_r, ld_row_nxt;
  idx_t  ld_col_r, ld_col_nxt;
  idx_t  rd_row_r, rd_row_nxt;
  idx_t  rd_col_r, rd_col_nxt;
  logic  out_valid_r, out_valid_nxt;
  idx_t  out_row_r, out_col_r;
  logic  out_last_r;

  word_t mem [DEPTH];
  word_t rd_data_r;

  logic  wr_en, rd_en, cfg_wr;
  logic  ld_col_end, ld_row_end, rd_col_end, rd_row_end;
  idx_t  cfg_side_m1;
  addr_t wr_addr, rd_addr;

  assign ld_col_end = (ld_col_r == side_m1_r);
  assign ld_row_end = (ld_row_r == side_m1_r);
  assign rd_col_end = (rd_col_r == side_m1_r);
  assign rd_row_end = (rd_row_r == side_m1_r);

  // Entries sit at a fixed row pitch of MAX_SIDE, so the rotated source
  // address is a plain concatenation of source row and column.
  assign wr_addr = {ld_row_r, ld_col_r};
  assign rd_addr = {side_m1_r - rd_col_r, rd_row_r};

  always_comb begin
    priority if (cfg_matrix_size == '0) begin
      cfg_side_m1 = '0;
    end else if (cfg_matrix_size > SIZE_MAX) begin
      cfg_side_m1 = IDX_TOP;
    end else begin
      cfg_side_m1 = IDX_W'(cfg_matrix_size - SIZE_W'(1));
    end
  end

  // Control outputs of the state machine.
  always_comb begin
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    rd_en     = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready  = 1'b1;
        cfg_ready = 1'b1;
      end
      ST_READ: begin
        rd_en = !out_valid_r || out_ready;
      end
      default: ;
    endcase
  end

  assign wr_en  = in_valid && in_ready;
  assign cfg_wr = cfg_valid && cfg_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (wr_en && !cfg_wr && ld_col_end && ld_row_end) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (rd_en && rd_col_end && rd_row_end) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Load and readout position counters.
  always_comb begin
    ld_row_nxt = ld_row_r;
    ld_col_nxt = ld_col_r;
    rd_row_nxt = rd_row_r;
    rd_col_nxt = rd_col_r;
    priority if (cfg_wr) begin
      ld_row_nxt = '0;
      ld_col_nxt = '0;
    end else if (wr_en) begin
      if (ld_col_end) begin
        ld_col_nxt = '0;
        ld_row_nxt = ld_row_end ? '0 : ld_row_r + idx_t'(1);
      end else begin
        ld_col_nxt = ld_col_r + idx_t'(1);
      end
    end
    if (rd_en) begin
      if (rd_col_end) begin
        rd_col_nxt = '0;
        rd_row_nxt = rd_row_end ? '0 : rd_row_r + idx_t'(1);
      end else begin
        rd_col_nxt = rd_col_r + idx_t'(1);
      end
    end
    out_valid_nxt = rd_en ? 1'b1 : (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      side_m1_r   <= IDX_TOP;
      ld_row_r    <= '0;
      ld_col_r    <= '0;
      rd_row_r    <= '0;
      rd_col_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ld_row_r    <= ld_row_nxt;
      ld_col_r    <= ld_col_nxt;
      rd_row_r    <= rd_row_nxt;
      rd_col_r    <= rd_col_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        side_m1_r <= cfg_side_m1;
      end
    end
  end

  // Element buffer; its registered read port doubles as the output register.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= word_t'(in_element);
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      out_row_r  <= rd_row_r;
      out_col_r  <= rd_col_r;
      out_last_r <= rd_col_end && rd_row_end;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_rotated_element = $signed(rd_data_r);
  assign out_row             = out_row_r;
  assign out_col             = out_col_r;
  assign out_last            = out_last_r;

endmodule

@@ tb/sv/square_matrix_rotate_cw_tb.sv @@
// Self-checking testbench for the clockwise square matrix rotator.
module square_matrix_rotate_cw_tb;
  import sqrot_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE       = 4;

  typedef enum logic [1:0] {
    OP_CFG,
    OP_ELEM,
    OP_RUN
  } stim_op_t;

  typedef struct packed {
    logic [DATA_W-1:0] elem;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              last;
  } rot_t;

  typedef struct {
    stim_op_t          op;
    logic [DATA_W-1:0] value;
    int unsigned       count;
    bit                typed;
    rot_t              want;
  } stim_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [DATA_W-1:0] in_element;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] out_rotated_element;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic                     out_last;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [SIZE_W-1:0]        cfg_matrix_size;

  square_matrix_rotate_cw dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_element          (in_element),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_rotated_element (out_rotated_element),
    .out_row             (out_row),
    .out_col             (out_col),
    .out_last            (out_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_matrix_size     (cfg_matrix_size)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the block: loaded elements, load progress and side register.
  logic [DATA_W-1:0] shadow_matrix [DEPTH];
  int unsigned       shadow_count;
  logic [SIZE_W-1:0] shadow_size;

  rot_t        pending_rotated [$];
  int unsigned failures;
  bit          in_quiet;
  bit          out_quiet;
  stim_row_t   directed_rows [16];

  function automatic int unsigned shadow_side();
    int unsigned n;
    n = shadow_size;
    if (n == 0) n = 1;
    if (n > MAX_SIDE) n = MAX_SIDE;
    return n;
  endfunction

  // Loads one element; on the final one queues the whole rotated matrix if keep is set.
  function automatic void predict_element(logic [DATA_W-1:0] value, bit keep);
    int unsigned n;
    int unsigned total;
    int unsigned k;
    rot_t        item;
    n = shadow_side();
    total = n * n;
    if (shadow_count >= total) shadow_count = 0;
    shadow_matrix[shadow_count] = value;
    shadow_count++;
    if (shadow_count < total) return;
    k = 0;
    for (int unsigned r = 0; r < n; r++) begin
      for (int unsigned c = 0; c < n; c++) begin
        item.elem = shadow_matrix[(n - 1 - c) * n + r];
        item.row  = IDX_W'(r);
        item.col  = IDX_W'(c);
        k++;
        item.last = (k == total);
        if (keep) pending_rotated.push_back(item);
      end
    end
    shadow_count = 0;
  endfunction

  function automatic logic [DATA_W-1:0] random_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return SIZE_W'($urandom_range(MAX_SIDE + 1, 15));
      1: return '0;
      2: return SIZE_MAX;
      default: return SIZE_W'($urandom_range(1, MAX_SIDE - 1));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_element(logic [DATA_W-1:0] value, bit keep);
    int unsigned gap;
    gap = in_quiet ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_element = value;
    do @(posedge clk); while (!in_ready);
    predict_element(value, keep);
    @(negedge clk);
  endtask

  task automatic drain(int unsigned extra);
    in_valid = 1'b0;
    while (pending_rotated.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] size);
    drain(SETTLE);
    cfg_valid       = 1'b1;
    cfg_matrix_size = size;
    do @(posedge clk); while (!cfg_ready);
    shadow_size  = size;
    shadow_count = 0;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Receiver: a fresh stall is drawn for every result.
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      stall = out_quiet ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    rot_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rotated.size() == 0) begin
        $error("unexpected result: element %h row %0d col %0d last %0d",
               out_rotated_element, out_row, out_col, out_last);
        failures++;
      end else begin
        want = pending_rotated.pop_front();
        if (out_rotated_element !== want.elem) begin
          $error("rotated_element: expected %h, got %h", want.elem, out_rotated_element);
          failures++;
        end
        if (out_row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, out_row);
          failures++;
        end
        if (out_col !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, out_col);
          failures++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          failures++;
        end
      end
    end
  end

  // Ends the run if no request of any kind completes for too long.
  int unsigned quiet_cycles;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned random_sent;
    int unsigned total;
    bit          partial_open;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_element      = '0;
    cfg_valid       = 1'b0;
    cfg_matrix_size = '0;
    failures        = 0;
    quiet_cycles    = 0;
    in_quiet        = 1'b0;
    out_quiet       = 1'b0;
    shadow_size     = SIZE_MAX;
    shadow_count    = 0;

    // A size-one matrix comes back unchanged at row 0, column 0 with last set.
    directed_rows = '{
      '{OP_RUN,  32'h0,          64, 1'b0, '0},
      '{OP_CFG,  32'd1,          0,  1'b0, '0},
      '{OP_ELEM, 32'h7FFF_FFFF,  0,  1'b1, '{32'h7FFF_FFFF, 3'd0, 3'd0, 1'b1}},
      '{OP_ELEM, 32'h8000_0000,  0,  1'b1, '{32'h8000_0000, 3'd0, 3'd0, 1'b1}},
      '{OP_CFG,  32'd0,          0,  1'b0, '0},
      '{OP_ELEM, 32'hFFFF_FFFF,  0,  1'b1, '{32'hFFFF_FFFF, 3'd0, 3'd0, 1'b1}},
      '{OP_ELEM, 32'h0000_0000,  0,  1'b1, '{32'h0000_0000, 3'd0, 3'd0, 1'b1}},
      '{OP_CFG,  32'd2,          0,  1'b0, '0},
      '{OP_ELEM, 32'h8000_0000,  0,  1'b0, '0},
      '{OP_ELEM, 32'h7FFF_FFFF,  0,  1'b0, '0},
      '{OP_ELEM, 32'hFFFF_FFFF,  0,  1'b0, '0},
      '{OP_ELEM, 32'h0000_0001,  0,  1'b0, '0},
      '{OP_ELEM, 32'h1111_1111,  0,  1'b0, '0},
      '{OP_ELEM, 32'h2222_2222,  0,  1'b0, '0},
      '{OP_CFG,  32'd3,          0,  1'b0, '0},
      '{OP_RUN,  32'h0,          9,  1'b0, '0}
    };

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // The first run fills a matrix at the side left by reset.
    foreach (directed_rows[i]) begin
      case (directed_rows[i].op)
        OP_CFG: write_size(directed_rows[i].value[SIZE_W-1:0]);
        OP_ELEM: begin
          if (directed_rows[i].typed) pending_rotated.push_back(directed_rows[i].want);
          send_element(directed_rows[i].value, !directed_rows[i].typed);
        end
        OP_RUN: repeat (directed_rows[i].count) send_element(random_word(), 1'b1);
        default: ;
      endcase
    end

    // Random phases: whole matrices back to back, now and then a partial load
    // that the next size write must throw away.
    random_sent  = 0;
    partial_open = 1'b0;
    while (random_sent < RANDOM_ITEMS) begin
      in_quiet  = ($urandom_range(0, 4) == 0);
      out_quiet = ($urandom_range(0, 4) == 0);
      if (partial_open || $urandom_range(0, 3) != 0) begin
        write_size(pick_size());
        partial_open = 1'b0;
      end
      total = shadow_side() * shadow_side();
      repeat ($urandom_range(1, 3) * total) begin
        send_element(random_word(), 1'b1);
        random_sent++;
      end
      if (total > 1 && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, total - 1)) begin
          send_element(random_word(), 1'b1);
          random_sent++;
        end
        partial_open = 1'b1;
      end
    end

    drain(4 * SETTLE);
    if (failures == 0 && pending_rotated.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
sv/sqrot_pkg.sv
sv/square_matrix_rotate_cw.sv
tb/sv/square_matrix_rotate_cw_tb.sv
